### rtl/pne_pkg.sv
// shared types and constants for the packet length nibble encoder
`timescale 1ns / 1ps

package pne_pkg;

  localparam logic       OP_HEADER = 1'b0;
  localparam logic       OP_DATA   = 1'b1;

  localparam logic [7:0] HDR_LEN_BIAS   = 8'd28;
  localparam logic [3:0] HDR_EVEN_BASE  = 4'h7;
  localparam logic [3:0] HDR_ODD_BASE   = 4'h3;
  localparam logic [3:0] HDR_LOW_MARK   = 4'h8;

  localparam logic [9:0] OFFSET_RESET   = 10'd593;
  localparam int         QUEUE_DEPTH_DEF = 2;

  localparam int         SYM_W   = 8;
  localparam int         OFF_W   = 10;
  localparam int         PLEN_W  = 11;
  localparam int         MAX_SYM = 4;

  // one encoded item: up to four symbols and the index of the final one
  typedef struct packed {
    logic [MAX_SYM-1:0][SYM_W-1:0] sym;
    logic [1:0]                    last_idx;
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

### rtl/pne_front.sv
// front end: accepts items, updates encoder state and forms symbol jobs
`timescale 1ns / 1ps

module pne_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // field_length [7:0], data_byte [15:8]
  input  logic              s_tuser,   // operation
  input  logic              s_tlast,   // last_byte
  input  pne_pkg::q_status_t q_status,
  output logic              push,
  output pne_pkg::job_t     push_job
);
  import pne_pkg::*;

  logic [3:0] prev_nib, prev_nib_next;
  logic [3:0] nib_idx, nib_idx_next;
  logic [7:0] checksum, checksum_next;

  logic [7:0] field_length, data_byte, len8, csum_sum;
  logic [3:0] base_hi;

  assign field_length = s_tdata[7:0];
  assign data_byte    = s_tdata[15:8];
  assign s_tready     = !q_status.full;
  assign push         = s_tvalid && s_tready;

  assign len8     = field_length + HDR_LEN_BIAS;
  assign base_hi  = (len8[4] ^ len8[0]) ? HDR_ODD_BASE : HDR_EVEN_BASE;
  assign csum_sum = checksum + data_byte;

  always_comb begin
    push_job      = '0;
    prev_nib_next = prev_nib;
    nib_idx_next  = nib_idx;
    checksum_next = checksum;
    unique case (s_tuser)
      OP_HEADER: begin
        push_job.sym[0]   = {base_hi, len8[7:4]};
        push_job.sym[1]   = {base_hi, len8[7:4]};
        push_job.sym[2]   = {base_hi | HDR_LOW_MARK, len8[3:0]};
        push_job.last_idx = 2'd2;
        prev_nib_next     = '0;
        nib_idx_next      = '0;
        checksum_next     = '0;
      end
      OP_DATA: begin
        push_job.sym[0] = {prev_nib ^ nib_idx, data_byte[7:4]};
        push_job.sym[1] = {data_byte[7:4] ^ (nib_idx + 4'd1), data_byte[3:0]};
        // checksum nibbles follow on the index after the data nibbles
        push_job.sym[2] = {data_byte[3:0] ^ (nib_idx + 4'd2), csum_sum[7:4]};
        push_job.sym[3] = {csum_sum[7:4] ^ (nib_idx + 4'd3), csum_sum[3:0]};
        checksum_next   = csum_sum;
        if (s_tlast) begin
          push_job.last_idx = 2'd3;
          prev_nib_next     = csum_sum[3:0];
          nib_idx_next      = nib_idx + 4'd4;
        end else begin
          push_job.last_idx = 2'd1;
          prev_nib_next     = data_byte[3:0];
          nib_idx_next      = nib_idx + 4'd2;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_nib <= '0;
      nib_idx  <= '0;
      checksum <= '0;
    end else if (push) begin
      prev_nib <= prev_nib_next;
      nib_idx  <= nib_idx_next;
      checksum <= checksum_next;
    end
  end

  a_hdr_clears: assert property (@(posedge clk) disable iff (rst)
    push && s_tuser == OP_HEADER |=> nib_idx == 4'd0 && checksum == 8'd0)
    else $error("header transfer did not clear encoder state");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    push && s_tuser == OP_DATA |=> nib_idx[0] == $past(nib_idx[0]))
    else $error("nibble index moved by an odd step");

endmodule

### rtl/pne_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module pne_queue #(
  parameter int DEPTH = pne_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pne_pkg::job_t      push_job,
  input  logic               pop,
  output pne_pkg::job_t      head_job,
  output pne_pkg::q_status_t status
);
  import pne_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full      = (count == CNT_FULL);
  assign status.not_empty = (count != '0);
  assign head_job         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.not_empty))
    else $error("pop from an empty queue");

endmodule

### rtl/pne_back.sv
// back end: plays out queued symbols one a cycle unless stalled, offset added
`timescale 1ns / 1ps

module pne_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pne_pkg::q_status_t   q_status,
  input  pne_pkg::job_t        head_job,
  output logic                 pop,
  input  logic [9:0]           symbol_offset,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // packet_length [10:0], zero [15:11]
  output logic                 m_tlast    // last_of_run
);
  import pne_pkg::*;

  logic [1:0]        sel;
  logic              load, sym_last;
  logic [PLEN_W-1:0] plen, plen_reg;

  assign load     = q_status.not_empty && (!m_tvalid || m_tready);
  assign sym_last = (sel == head_job.last_idx);
  assign pop      = load && sym_last;
  assign plen     = PLEN_W'(head_job.sym[sel]) + PLEN_W'(symbol_offset);
  assign m_tdata  = {5'b0, plen_reg};

  always_ff @(posedge clk) begin
    if (load) begin
      plen_reg <= plen;
      m_tlast  <= sym_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sel      <= sym_last ? 2'd0 : sel + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid && m_tlast)
    else $error("job retired without a last transfer");

  a_sel_in_range: assert property (@(posedge clk) disable iff (rst)
    q_status.not_empty |-> sel <= head_job.last_idx)
    else $error("symbol select ran past the end of the job");

endmodule

### rtl/packet_length_nibble_encoder_top.sv
// top level of the packet length nibble encoder
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata field_length, data_byte; tuser operation;
//                                     tlast last_byte
//  m_*      out  m_tvalid/m_tready    tdata packet_length; tlast last_of_run
//  cfg_*    in   cfg_wr_en            cfg_wr_data symbol_offset
//
// one symbol leaves per cycle from the back end output register unless stalled:
// a header gives 3 symbols, a data byte 2, a last data byte 4
// the front end takes a new item each cycle while the job queue has room
// reset clears encoder state, the queue and sets symbol_offset to 593
// a stalled output holds its transfer; the queue keeps the front running until full
`timescale 1ns / 1ps

module packet_length_nibble_encoder_top #(
  parameter int QUEUE_DEPTH = pne_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // field_length [7:0], data_byte [15:8]
  input  logic        s_tuser,   // operation
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // packet_length [10:0], zero [15:11]
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);
  import pne_pkg::*;

  logic [OFF_W-1:0] symbol_offset;
  logic             push, pop;
  job_t             push_job, head_job;
  q_status_t        q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_offset <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      symbol_offset <= cfg_wr_data;
    end
  end

  pne_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  pne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  pne_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head_job      (head_job),
    .pop           (pop),
    .symbol_offset (symbol_offset),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule

### test/tb_packet_length_nibble_encoder_top.sv
// self-checking testbench for the packet length nibble encoder top level
`timescale 1ns / 1ps

module tb_packet_length_nibble_encoder_top;
  import pne_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  // one input transfer, with the header lengths typed in where they are obvious
  typedef struct packed {
    logic                        op;
    logic [7:0]                  flen;
    logic [7:0]                  dbyte;
    logic                        lastb;
    logic                        typed;
    logic [0:2][PLEN_W-1:0]      lens;
  } enc_item_t;

  typedef struct packed {
    logic [PLEN_W-1:0] plen;
    logic              last;
  } length_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;

  // encoder state as predicted
  logic [3:0]       prev_nibble;
  logic [3:0]       nibble_idx;
  logic [7:0]       byte_sum;
  logic [OFF_W-1:0] offset_model;
  logic [7:0]       next_syms [0:3];
  int               next_count;

  length_beat_t pending_lengths [$];
  enc_item_t    current_item;
  enc_item_t    directed_rows [22];
  int           gap_pct = 25;
  int           hold_off = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  packet_length_nibble_encoder_top DUT (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nibble_symbol(input logic [3:0] nib);
    logic [7:0] sym;
    sym = {prev_nibble ^ nibble_idx, nib};
    nibble_idx = nibble_idx + 4'd1;
    prev_nibble = nib;
    return sym;
  endfunction

  // symbols caused by one input transfer, advancing the predicted state
  function automatic void encode_item(input enc_item_t it);
    logic [7:0] len8;
    logic [3:0] base;
    if (it.op == OP_HEADER) begin
      len8 = it.flen + HDR_LEN_BIAS;
      // nibble sum is even when the two low bits agree
      base = (len8[4] == len8[0]) ? HDR_EVEN_BASE : HDR_ODD_BASE;
      prev_nibble = '0;
      nibble_idx = '0;
      byte_sum = '0;
      next_syms[0] = {base, len8[7:4]};
      next_syms[1] = {base, len8[7:4]};
      next_syms[2] = {base | HDR_LOW_MARK, len8[3:0]};
      next_count = 3;
    end else begin
      next_syms[0] = nibble_symbol(it.dbyte[7:4]);
      next_syms[1] = nibble_symbol(it.dbyte[3:0]);
      byte_sum = byte_sum + it.dbyte;
      next_count = 2;
      if (it.lastb) begin
        next_syms[2] = nibble_symbol(byte_sum[7:4]);
        next_syms[3] = nibble_symbol(byte_sum[3:0]);
        next_count = 4;
      end
    end
  endfunction

  function automatic void flag_mismatch(input string what, input int exp_len,
                                        input int exp_last);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s): expected length %0d last %0d, got tdata 0x%04h last %0b",
               what, exp_len, exp_last, m_tdata, m_tlast);
  endfunction

  // receiver side: random hold-offs on tready
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off--;
    end else if ($urandom_range(0, 99) < gap_pct) begin
      m_tready <= 1'b0;
      hold_off = pick_gap() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // accepted transfers on both sides, prediction, checking and watchdog
  always @(posedge clk) begin : monitor
    length_beat_t beat;
    logic         moved;
    moved = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        encode_item(current_item);
        for (int k = 0; k < next_count; k++) begin
          beat.plen = current_item.typed ? current_item.lens[k]
                                         : PLEN_W'(next_syms[k]) + PLEN_W'(offset_model);
          beat.last = (k == next_count - 1);
          pending_lengths.push_back(beat);
        end
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (pending_lengths.size() == 0) begin
          flag_mismatch("unexpected transfer", -1, -1);
        end else begin
          beat = pending_lengths.pop_front();
          if (m_tdata !== {{(16 - PLEN_W){1'b0}}, beat.plen} || m_tlast !== beat.last)
            flag_mismatch("field", int'(beat.plen), int'(beat.last));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // leaves tvalid high after the transfer so back-to-back items need no gap
  task automatic send_item(input enc_item_t it);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    current_item = it;
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.dbyte, it.flen};
    s_tlast  <= it.lastb;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_lengths.size() != 0) @(negedge clk);
  endtask

  // called at a falling edge with the block idle
  task automatic set_offset(input logic [OFF_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    offset_model = value;
  endtask

  // mostly well-formed fields with random content, some cut short, some noise
  task automatic run_random(input int quota);
    enc_item_t it;
    int        sent;
    int        n;
    int        cut;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 80) begin
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
        it = '0;
        it.op   = OP_HEADER;
        it.flen = 8'(n);
        send_item(it);
        sent++;
        for (int k = 0; k < cut; k++) begin
          it = '0;
          it.op    = OP_DATA;
          it.flen  = 8'($urandom_range(0, 255));
          it.dbyte = 8'($urandom_range(0, 255));
          it.lastb = (k == n - 1);
          send_item(it);
          sent++;
        end
      end else begin
        it = '0;
        it.op    = 1'($urandom_range(0, 1));
        it.flen  = 8'($urandom_range(0, 255));
        it.dbyte = 8'($urandom_range(0, 255));
        it.lastb = 1'($urandom_range(0, 1));
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_HEADER;
    s_tlast      = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    m_tready     = 1'b0;
    prev_nibble  = '0;
    nibble_idx   = '0;
    byte_sum     = '0;
    offset_model = OFFSET_RESET;
    current_item = '0;

    // header lengths typed in assume the reset offset
    directed_rows = '{
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},  // data before any header
      '{OP_DATA,   8'h00, 8'h00, 1'b1, 1'b0, '0},
      '{OP_HEADER, 8'd0,   8'h00, 1'b0, 1'b1, '{11'd642, 11'd642, 11'd781}},
      '{OP_HEADER, 8'd255, 8'h00, 1'b0, 1'b1, '{11'd706, 11'd706, 11'd844}},
      '{OP_HEADER, 8'd228, 8'h00, 1'b0, 1'b1, '{11'd705, 11'd705, 11'd833}},  // len8 wraps to 0
      '{OP_HEADER, 8'd0,   8'hff, 1'b1, 1'b1, '{11'd642, 11'd642, 11'd781}},  // last flag ignored
      '{OP_HEADER, 8'd4,   8'h00, 1'b0, 1'b1, '{11'd707, 11'd707, 11'd833}},
      '{OP_DATA,   8'hff, 8'h00, 1'b0, 1'b0, '0},  // length ignored on data
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'ha5, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'h5a, 1'b1, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'h3c, 1'b0, 1'b0, '0},  // data after the last byte
      '{OP_DATA,   8'h00, 8'hc3, 1'b1, 1'b0, '0},
      '{OP_HEADER, 8'd1,   8'h00, 1'b0, 1'b1, '{11'd706, 11'd706, 11'd846}},
      // index wraps and the checksum overflows
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b0, 1'b0, '0},
      '{OP_DATA,   8'h00, 8'hff, 1'b1, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    wait_drained();
    set_offset('0);
    gap_pct = 30;
    run_random(70);

    // full rate on both sides with the largest offset
    wait_drained();
    set_offset('1);
    gap_pct = 0;
    run_random(70);

    wait_drained();
    set_offset(OFF_W'($urandom_range(1, 1022)));
    gap_pct = 50;
    run_random(80);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pne_pkg.sv
rtl/pne_front.sv
rtl/pne_queue.sv
rtl/pne_back.sv
rtl/packet_length_nibble_encoder_top.sv
test/tb_packet_length_nibble_encoder_top.sv
